### sv/cled_pkg.sv
// ----------------------------------------------------------------------------
// cled_pkg
// Shared types, constants and word tables for the console line editor.
// ----------------------------------------------------------------------------
package cled_pkg;

    localparam int LINE_SIZE = 32;
    localparam int IDX_W     = $clog2(LINE_SIZE);
    localparam int NUM_WORDS = 9;
    localparam int WORD_MAX  = 8;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_ARG  = 2'd2;

    localparam logic [3:0] CODE_NONE    = 4'd0;
    localparam logic [3:0] CODE_UNKNOWN = 4'd9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [7:0] WORD_CHARS [NUM_WORDS][WORD_MAX] = '{
        '{"c", "a", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"l", "s", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"r", "m", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"s", "a", "v", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"m", "k", "d", "i", "r", CH_NUL, CH_NUL, CH_NUL},
        '{"r", "m", "d", "i", "r", CH_NUL, CH_NUL, CH_NUL},
        '{"s", "h", "u", "t", "d", "o", "w", "n"},
        '{"b", "a", "t", "t", "e", "r", "y", CH_NUL},
        '{"h", "e", "l", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5, 4'd8, 4'd7, 4'd4
    };

    typedef struct packed {
        logic             done;
        logic             has_args;
        logic [IDX_W-1:0] astart;
        logic [IDX_W-1:0] slen;
        logic [3:0]       code;
    } t_scan;

endpackage

### sv/console_line_editor_command_decode_top.sv
// ----------------------------------------------------------------------------
// console_line_editor_command_decode_top
// Serial console line editor with command word decode.
// ----------------------------------------------------------------------------
// Input channel: one received byte per beat (i_valid / o_stall). Output
// channel: one result per beat (o_valid / i_stall): echo bytes, a command
// code at line end, then the argument bytes; o_last marks the final result
// of each input byte.
// An echo is loaded into the output register from S_ECHO, the state that
// follows the taking of a byte. An erase on a non-empty line gives three
// echo beats: BS, space, BS. A line end then adds a scan of the stored
// bytes through the line RAM read port, the command code and one beat per
// argument byte; a full line holds 31 bytes.
// The block takes one byte at a time: o_stall is high from the beat after
// a byte is taken until its last result is loaded into the output register.
// An output stall holds the output register and every step but the line scan.
// Reset (synchronous, active low) empties the line and drops any pending
// result; the line RAM itself is not cleared.
// ----------------------------------------------------------------------------
module console_line_editor_command_decode_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_data_byte,
    output logic [3:0] o_command_code,
    output logic       o_last
);
    import cled_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_SCAN,
        S_CMD,
        S_ARG
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_cnt;
    logic             r_erase;
    logic [1:0]       r_ecnt;
    logic [7:0]       r_ech;
    logic             r_lend;
    logic [IDX_W-1:0] r_ra;
    logic             r_rgo;
    logic             r_dv;
    logic [IDX_W-1:0] r_di;
    logic [IDX_W-1:0] r_aidx;
    logic             r_o_valid;
    logic [1:0]       r_o_kind;
    logic [7:0]       r_o_data;
    logic [3:0]       r_o_code;
    logic             r_o_last;

    logic             in_acc;
    logic             slot_free;
    logic             out_load;
    logic             is_erase;
    logic [IDX_W-1:0] cnt_inc;
    logic [IDX_W-1:0] last_idx;
    logic             line_end;
    logic             arg_last;
    logic [7:0]       echo_byte;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;
    t_scan            scan_res;

    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign slot_free = !r_o_valid || !i_stall;
    assign out_load  = slot_free && (r_state inside {S_ECHO, S_CMD, S_ARG});
    assign is_erase  = i_rx_byte inside {CH_BS, CH_DEL};
    assign cnt_inc   = r_cnt + 1'b1;
    assign last_idx  = r_cnt - 1'b1;
    assign line_end  = (i_rx_byte inside {CH_CR, CH_LF}) ||
                       (cnt_inc == IDX_W'(LINE_SIZE - 1));
    assign arg_last  = (r_aidx == scan_res.slen - 1'b1);
    assign echo_byte = r_erase ? ((r_ecnt == 2'd1) ? CH_SPACE : CH_BS) : r_ech;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_ra;
        case (r_state)
            S_SCAN: begin
                ram_re = r_rgo;
            end
            S_CMD: begin
                ram_re    = slot_free && scan_res.has_args;
                ram_raddr = scan_res.astart;
            end
            S_ARG: begin
                ram_re    = slot_free && !arg_last;
                ram_raddr = r_aidx + 1'b1;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    cled_ram #(
        .WIDTH(8),
        .DEPTH(LINE_SIZE)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && !is_erase),
        .i_waddr(r_cnt),
        .i_wdata(i_rx_byte),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    cled_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc),
        .i_valid  (r_dv),
        .i_byte   (ram_rdata),
        .i_idx    (r_di),
        .i_end_idx(last_idx),
        .o_res    (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rgo     <= 1'b0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            r_dv <= (r_state == S_SCAN) && r_rgo;
            r_di <= r_ra;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (is_erase) begin
                            if (r_cnt != '0) begin
                                r_erase <= 1'b1;
                                r_ecnt  <= 2'd2;
                                r_cnt   <= last_idx;
                                r_lend  <= 1'b0;
                                r_state <= S_ECHO;
                            end
                        end else begin
                            r_erase <= 1'b0;
                            r_ecnt  <= 2'd0;
                            r_ech   <= i_rx_byte;
                            r_cnt   <= cnt_inc;
                            r_lend  <= line_end;
                            r_state <= S_ECHO;
                        end
                    end
                end
                S_ECHO: begin
                    if (slot_free) begin
                        r_o_kind  <= KIND_ECHO;
                        r_o_data  <= echo_byte;
                        r_o_code  <= CODE_NONE;
                        r_o_last  <= (r_ecnt == 2'd0) && !r_lend;
                        if (r_ecnt == 2'd0) begin
                            if (r_lend) begin
                                r_ra    <= '0;
                                r_rgo   <= 1'b1;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_ecnt <= r_ecnt - 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rgo) begin
                        r_ra <= r_ra + 1'b1;
                        if (r_ra == last_idx) begin
                            r_rgo <= 1'b0;
                        end
                    end
                    if (scan_res.done) begin
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    if (slot_free) begin
                        r_o_kind  <= KIND_CMD;
                        r_o_data  <= CH_NUL;
                        r_o_code  <= scan_res.code;
                        r_o_last  <= !scan_res.has_args;
                        r_cnt     <= '0;
                        if (scan_res.has_args) begin
                            r_aidx  <= scan_res.astart;
                            r_state <= S_ARG;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ARG: begin
                    if (slot_free) begin
                        r_o_kind  <= KIND_ARG;
                        r_o_data  <= ram_rdata;
                        r_o_code  <= CODE_NONE;
                        r_o_last  <= arg_last;
                        if (arg_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_aidx <= r_aidx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_result_kind  = r_o_kind;
    assign o_data_byte    = r_o_data;
    assign o_command_code = r_o_code;
    assign o_last         = r_o_last;

endmodule

### sv/cled_ram.sv
// ----------------------------------------------------------------------------
// cled_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cled_scan.sv
// ----------------------------------------------------------------------------
// cled_scan
// Line scanner: takes stored bytes in order and finds the cut length, the
// first space, the argument start and the command word match.
// ----------------------------------------------------------------------------
module cled_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_valid,
    input  logic [7:0]                i_byte,
    input  logic [cled_pkg::IDX_W-1:0] i_idx,
    input  logic [cled_pkg::IDX_W-1:0] i_end_idx,
    output cled_pkg::t_scan           o_res
);
    import cled_pkg::*;

    logic                 r_done, n_done;
    logic                 r_found, n_found;
    logic                 r_pend, n_pend;
    logic                 r_aset, n_aset;
    logic [NUM_WORDS-1:0] r_mis, n_mis;
    logic [IDX_W-1:0]     r_sp, n_sp;
    logic [IDX_W-1:0]     r_slen, n_slen;
    logic [IDX_W-1:0]     r_astart, n_astart;
    logic                 crlf;
    logic                 in_word;
    logic [2:0]           pos;
    logic [IDX_W-1:0]     cmd_len;
    logic [3:0]           code;

    assign crlf    = i_byte inside {CH_CR, CH_LF};
    assign in_word = 32'(i_idx) < 32'(WORD_MAX);
    assign pos     = 3'(i_idx);

    always_comb begin
        n_done   = r_done;
        n_found  = r_found;
        n_pend   = r_pend;
        n_aset   = r_aset;
        n_mis    = r_mis;
        n_sp     = r_sp;
        n_slen   = r_slen;
        n_astart = r_astart;
        if (i_start) begin
            n_done   = 1'b0;
            n_found  = 1'b0;
            n_pend   = 1'b0;
            n_aset   = 1'b0;
            n_mis    = '0;
            n_sp     = '0;
            n_slen   = '0;
            n_astart = '0;
        end else if (i_valid && !r_done) begin
            if (i_byte == CH_NUL) begin
                n_done = 1'b1;
            end else begin
                if (!crlf) begin
                    n_slen = i_idx + 1'b1;
                end
                if (!r_found) begin
                    if (i_byte == CH_SPACE) begin
                        n_found = 1'b1;
                        n_sp    = i_idx;
                        if (r_pend) begin
                            n_mis = '1;
                        end
                    end else if (crlf) begin
                        n_pend = 1'b1;
                    end else begin
                        for (int w = 0; w < NUM_WORDS; w++) begin
                            if (r_pend || (in_word && i_byte != WORD_CHARS[w][pos])) begin
                                n_mis[w] = 1'b1;
                            end
                        end
                        n_pend = 1'b0;
                    end
                end else if (!r_aset && i_byte != CH_SPACE) begin
                    n_aset   = 1'b1;
                    n_astart = i_idx;
                end
                if (i_idx == i_end_idx) begin
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_pend  <= 1'b0;
            r_aset  <= 1'b0;
            r_mis   <= '0;
        end else begin
            r_done  <= n_done;
            r_found <= n_found;
            r_pend  <= n_pend;
            r_aset  <= n_aset;
            r_mis   <= n_mis;
        end
        r_sp     <= n_sp;
        r_slen   <= n_slen;
        r_astart <= n_astart;
    end

    assign cmd_len = r_found ? r_sp : r_slen;

    always_comb begin
        code = CODE_UNKNOWN;
        for (int w = NUM_WORDS - 1; w >= 0; w--) begin
            if (!r_mis[w] && 32'(cmd_len) == 32'(WORD_LEN[w])) begin
                code = 4'(w);
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.has_args = r_found && r_aset && (r_astart < r_slen);
    assign o_res.astart   = r_astart;
    assign o_res.slen     = r_slen;
    assign o_res.code     = code;

endmodule

### sv/cled_checker.sv
// ----------------------------------------------------------------------------
// cled_checker
// Port-level checks for the console line editor, bound to the top level.
// ----------------------------------------------------------------------------
module cled_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_result_kind,
    input logic [7:0] o_data_byte,
    input logic [3:0] o_command_code,
    input logic       o_last
);
    import cled_pkg::*;

    // a stalled beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) &&
        $stable(o_data_byte) && $stable(o_command_code) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid)
        else $error("output beat valid right after reset");

    a_code_only_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_CMD |-> o_command_code == CODE_NONE)
        else $error("command code on a byte beat");

    a_cmd_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_CMD |->
        o_data_byte == CH_NUL && o_command_code <= CODE_UNKNOWN)
        else $error("bad command beat");

    // an argument beat never follows a finished result sequence
    a_arg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !(o_valid && o_result_kind == KIND_ARG))
        else $error("argument beat after last");

endmodule

bind console_line_editor_command_decode_top cled_checker u_cled_checker (.*);

### tb/console_line_editor_command_decode_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor_command_decode_top_test
// Self-checking bench for the console line editor with command decode.
// Received bytes go in one beat at a time; every echo, command and argument
// beat that comes out is checked against a line-buffer model kept in the
// bench or, for the typed rows, a table of results. A short table covers
// erase, empty lines, extreme bytes and splitting. Random command lines,
// noise and full lines follow, with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
module console_line_editor_command_decode_top_test;
    import cled_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 100;
    localparam logic [3:0] CODE_LS = 4'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] code;
        logic       last;
    } t_console_out;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [1:0] n_typed;
    } t_edit_row;

    localparam int N_ROWS = 23;
    localparam t_edit_row EDIT_ROWS [N_ROWS] = '{
        '{CH_BS, 1'b1, 2'd0},
        '{CH_DEL, 1'b1, 2'd0},
        '{"l", 1'b1, 2'd1},
        '{"s", 1'b1, 2'd1},
        '{CH_CR, 1'b1, 2'd2},
        '{"x", 1'b1, 2'd1},
        '{CH_DEL, 1'b1, 2'd3},
        '{CH_LF, 1'b1, 2'd2},
        '{CH_SPACE, 1'b0, 2'd0},
        '{"a", 1'b0, 2'd0},
        '{CH_CR, 1'b0, 2'd0},
        '{"r", 1'b0, 2'd0},
        '{"m", 1'b0, 2'd0},
        '{CH_SPACE, 1'b0, 2'd0},
        '{CH_SPACE, 1'b0, 2'd0},
        '{"z", 1'b0, 2'd0},
        '{CH_NUL, 1'b0, 2'd0},
        '{8'hFF, 1'b0, 2'd0},
        '{CH_LF, 1'b0, 2'd0},
        '{"c", 1'b0, 2'd0},
        '{"a", 1'b0, 2'd0},
        '{"t", 1'b0, 2'd0},
        '{CH_CR, 1'b0, 2'd0}
    };

    localparam int N_TYPED = 10;
    localparam t_console_out TYPED_OUT [N_TYPED] = '{
        '{KIND_ECHO, "l", CODE_NONE, 1'b1},
        '{KIND_ECHO, "s", CODE_NONE, 1'b1},
        '{KIND_ECHO, CH_CR, CODE_NONE, 1'b0},
        '{KIND_CMD, CH_NUL, CODE_LS, 1'b1},
        '{KIND_ECHO, "x", CODE_NONE, 1'b1},
        '{KIND_ECHO, CH_BS, CODE_NONE, 1'b0},
        '{KIND_ECHO, CH_SPACE, CODE_NONE, 1'b0},
        '{KIND_ECHO, CH_BS, CODE_NONE, 1'b1},
        '{KIND_ECHO, CH_LF, CODE_NONE, 1'b0},
        '{KIND_CMD, CH_NUL, CODE_UNKNOWN, 1'b1}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_result_kind;
    logic [7:0] o_data_byte;
    logic [3:0] o_command_code;
    logic       o_last;

    string        cmd_words [NUM_WORDS] = '{
        "cat", "ls", "rm", "save", "mkdir", "rmdir", "shutdown", "battery", "help"
    };
    logic [7:0]   line_buf [LINE_SIZE];
    int           line_fill = 0;
    t_console_out awaited_console_out [$];
    t_console_out seen_out;
    int           mismatch_count = 0;
    int           clk_count = 0;
    int           burst_left = 0;
    int           stall_mode = 0;
    int           stall_left = 0;
    int           answered_bytes = 0;

    console_line_editor_command_decode_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_rx_byte      (i_rx_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_data_byte    (o_data_byte),
        .o_command_code (o_command_code),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        clk_count <= clk_count + 1;
        if (clk_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still awaited", $time,
                     awaited_console_out.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output stall: modes of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 80);
            end
            stall_left--;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 2) == 0);
                2: i_stall <= ((clk_count % 4) < 2);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic void edit_line(input logic [7:0] c, output t_console_out res[$]);
        t_console_out r;
        int len, sp, arg_from, w, i;
        bit found, hit;
        res = {};
        if (c == CH_BS || c == CH_DEL) begin
            if (line_fill == 0) return;
            res.push_back('{KIND_ECHO, CH_BS, CODE_NONE, 1'b0});
            res.push_back('{KIND_ECHO, CH_SPACE, CODE_NONE, 1'b0});
            res.push_back('{KIND_ECHO, CH_BS, CODE_NONE, 1'b1});
            line_fill--;
            return;
        end
        res.push_back('{KIND_ECHO, c, CODE_NONE, 1'b0});
        if (line_fill < LINE_SIZE - 1) begin
            line_buf[line_fill] = c;
            line_fill++;
        end
        if (c == CH_CR || c == CH_LF || line_fill == LINE_SIZE - 1) begin
            len = 0;
            while (len < line_fill && line_buf[len] != CH_NUL) len++;
            while (len > 0 && (line_buf[len-1] == CH_CR || line_buf[len-1] == CH_LF)) len--;
            sp = len;
            found = 1'b0;
            for (i = 0; i < len; i++) begin
                if (!found && line_buf[i] == CH_SPACE) begin
                    sp = i;
                    found = 1'b1;
                end
            end
            arg_from = len;
            if (found) begin
                arg_from = sp + 1;
                while (arg_from < len && line_buf[arg_from] == CH_SPACE) arg_from++;
            end
            r = '{KIND_CMD, CH_NUL, CODE_UNKNOWN, 1'b0};
            for (w = 0; w < NUM_WORDS; w++) begin
                if (sp > 0 && cmd_words[w].len() == sp) begin
                    hit = 1'b1;
                    for (i = 0; i < sp; i++) begin
                        if (cmd_words[w][i] != line_buf[i]) hit = 1'b0;
                    end
                    if (hit) r.code = 4'(w);
                end
            end
            res.push_back(r);
            for (i = arg_from; i < len; i++) begin
                res.push_back('{KIND_ARG, line_buf[i], CODE_NONE, 1'b0});
            end
            line_fill = 0;
        end
        r = res.pop_back();
        r.last = 1'b1;
        res.push_back(r);
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_console_out.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual kind %0d data %0d code %0d",
                         $time, o_result_kind, o_data_byte, o_command_code);
                mismatch_count++;
            end else begin
                seen_out = awaited_console_out.pop_front();
                if (o_result_kind !== seen_out.kind)
                    report_field("result_kind", seen_out.kind, o_result_kind);
                if (o_data_byte !== seen_out.data)
                    report_field("data_byte", seen_out.data, o_data_byte);
                if (o_command_code !== seen_out.code)
                    report_field("command_code", seen_out.code, o_command_code);
                if (o_last !== seen_out.last)
                    report_field("last", seen_out.last, o_last);
            end
        end
    end

    // bursts of random length, gaps of random length, some stretches gap-free
    task automatic drive_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 0) gap = 40;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_predicted(input logic [7:0] b);
        t_console_out res [$];
        drive_byte(b);
        edit_line(b, res);
        foreach (res[k]) awaited_console_out.push_back(res[k]);
        if (res.size() > 0) answered_bytes++;
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_console_out.size() != 0);
    endtask

    task automatic send_random_line(input bit full_lead_space, input bit force_full);
        logic [7:0] bytes [$];
        int mode, w, n, k;
        mode = force_full ? 1 : $urandom_range(0, 9);
        if (mode == 0) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) bytes.push_back(8'($urandom_range(0, 255)));
        end else if (mode == 1) begin
            n = LINE_SIZE - 1 - line_fill;
            for (k = 0; k < n; k++) begin
                if (k == 0 && full_lead_space && line_fill == 0) begin
                    bytes.push_back(CH_SPACE);
                end else begin
                    bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
                    if (bytes[$] == CH_DEL) bytes[$] = 8'h7E;
                end
            end
        end else begin
            if ($urandom_range(0, 7) == 0) bytes.push_back(CH_SPACE);
            w = $urandom_range(0, NUM_WORDS);
            if (w == NUM_WORDS) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
            end else begin
                for (k = 0; k < cmd_words[w].len(); k++) bytes.push_back(cmd_words[w][k]);
            end
            if ($urandom_range(0, 5) == 0) begin
                bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
                bytes.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
            end
            case ($urandom_range(0, 3))
                0: ;
                1: repeat ($urandom_range(1, 2)) bytes.push_back(CH_SPACE);
                default: begin
                    repeat ($urandom_range(1, 3)) bytes.push_back(CH_SPACE);
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++) bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    if ($urandom_range(0, 7) == 0) begin
                        bytes.push_back(CH_NUL);
                        bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    end
                end
            endcase
            bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
        foreach (bytes[k]) send_predicted(bytes[k]);
    endtask

    initial begin
        t_console_out res [$];
        int typed_pos;
        bit mid_pause_done;
        typed_pos = 0;
        mid_pause_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            drive_byte(EDIT_ROWS[r].rx);
            edit_line(EDIT_ROWS[r].rx, res);
            if (EDIT_ROWS[r].typed) begin
                for (int k = 0; k < EDIT_ROWS[r].n_typed; k++) begin
                    awaited_console_out.push_back(TYPED_OUT[typed_pos]);
                    typed_pos++;
                end
            end else begin
                foreach (res[k]) awaited_console_out.push_back(res[k]);
            end
        end
        wait_all_results();

        send_random_line(1'b1, 1'b1);
        while (answered_bytes < RANDOM_ITEMS) begin
            send_random_line($urandom_range(0, 1), 1'b0);
            if (!mid_pause_done && answered_bytes >= RANDOM_ITEMS / 2) begin
                wait_all_results();
                mid_pause_done = 1'b1;
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
sv/cled_pkg.sv
sv/cled_ram.sv
sv/cled_scan.sv
sv/console_line_editor_command_decode_top.sv
sv/cled_checker.sv
tb/console_line_editor_command_decode_top_test.sv
